/* hdl/utf8d_pkg.sv */
// shared types and constants of the utf-8 decoder
// used by utf8d_ctrl, utf8d_datapath and utf8_decoder_with_replacement_unit
`default_nettype none

package utf8d_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_SCALAR     = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURROGATE_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] SURROGATE_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_TWO_BYTE   = 21'h000080;
    localparam logic [CP_W-1:0] MIN_THREE_BYTE = 21'h000800;
    localparam logic [CP_W-1:0] MIN_FOUR_BYTE  = 21'h010000;

    // resolution of the sequence at the head of the buffer
    typedef enum logic [2:0] {
        OC_EMPTY,  // nothing buffered
        OC_WAIT,   // sequence incomplete, stream goes on
        OC_CLEAR,  // sequence incomplete at stream end: one replacement, drop all
        OC_BAD,    // bad lead or failed sequence: one replacement, drop lead
        OC_GOOD    // valid sequence: code point, drop whole sequence
    } t_outcome;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // append accepted byte to the buffer
        logic advance;    // apply head resolution, hold its result
        logic push;       // move held result to the output register
        logic push_last;  // the pushed result ends the run of this byte
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        t_outcome outcome;
        logic     held_valid;
        logic     out_free;
    } t_sts;

endpackage

`default_nettype wire

/* hdl/utf8d_datapath.sv */
// byte buffer, head-of-buffer decode and result registers of the utf-8 decoder
// depends on utf8d_pkg
`default_nettype none

module utf8d_datapath
    import utf8d_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_cmd            i_cmd,
    output t_sts                 o_sts,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_last_byte,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output logic [CP_W-1:0]      o_code_point,
    output logic                 o_last_of_run,
    output logic                 o_stream_end
);

    logic [7:0]      r_buf [4];
    logic [2:0]      r_count;
    logic [2:0]      n_count;
    logic            r_at_end;
    logic            r_held_valid;
    logic [CP_W-1:0] r_held_cp;
    logic            r_out_valid;
    logic [CP_W-1:0] r_out_cp;
    logic            r_out_last;
    logic            r_out_end;

    logic [7:0]      lead;
    logic [2:0]      seq_len;
    logic            cont_ok;
    logic [CP_W-1:0] seq_cp;
    logic            range_bad;
    t_outcome        outcome;
    logic [2:0]      drop;
    logic [CP_W-1:0] emit_cp;

    // lead byte class and announced length
    always_comb begin
        lead = r_buf[0];
        priority if (lead[7] == 1'b0) begin
            seq_len = 3'd1;
        end else if (lead[7:5] == 3'b110) begin
            seq_len = 3'd2;
        end else if (lead[7:4] == 4'b1110) begin
            seq_len = 3'd3;
        end else if (lead[7:3] == 5'b11110) begin
            seq_len = 3'd4;
        end else begin
            seq_len = 3'd0;
        end
    end

    // continuation bytes and assembled value
    always_comb begin
        cont_ok = 1'b1;
        for (int j = 1; j < 4; j++) begin
            if ((3'(j) < seq_len) && (r_buf[j][7:6] != 2'b10)) begin
                cont_ok = 1'b0;
            end
        end
        case (seq_len)
            3'd1:    seq_cp = {14'd0, lead[6:0]};
            3'd2:    seq_cp = {10'd0, lead[4:0], r_buf[1][5:0]};
            3'd3:    seq_cp = {5'd0, lead[3:0], r_buf[1][5:0], r_buf[2][5:0]};
            3'd4:    seq_cp = {lead[2:0], r_buf[1][5:0], r_buf[2][5:0], r_buf[3][5:0]};
            default: seq_cp = '0;
        endcase
        range_bad = ((seq_len == 3'd2) && (seq_cp < MIN_TWO_BYTE))
                 || ((seq_len == 3'd3) && (seq_cp < MIN_THREE_BYTE))
                 || ((seq_len == 3'd4) && (seq_cp < MIN_FOUR_BYTE))
                 || (seq_cp > MAX_SCALAR)
                 || ((seq_cp >= SURROGATE_LO) && (seq_cp <= SURROGATE_HI));
    end

    // resolution of the head sequence
    always_comb begin
        priority if (r_count == 3'd0) begin
            outcome = OC_EMPTY;
        end else if (seq_len == 3'd0) begin
            outcome = OC_BAD;
        end else if (r_count < seq_len) begin
            outcome = r_at_end ? OC_CLEAR : OC_WAIT;
        end else if (cont_ok && !range_bad) begin
            outcome = OC_GOOD;
        end else begin
            outcome = OC_BAD;
        end
        unique case (outcome)
            OC_GOOD:  drop = seq_len;
            OC_BAD:   drop = 3'd1;
            OC_CLEAR: drop = 3'd4;
            default:  drop = 3'd0;
        endcase
        emit_cp = (outcome == OC_GOOD) ? seq_cp : REPLACEMENT_CP;
        n_count = (drop >= r_count) ? 3'd0 : (r_count - drop);
    end

    // buffer contents and held result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_buf[r_count[1:0]] <= i_byte;
            r_at_end            <= i_last_byte;
        end else if (i_cmd.advance) begin
            r_held_cp <= emit_cp;
            case (drop)
                3'd1: begin
                    r_buf[0] <= r_buf[1];
                    r_buf[1] <= r_buf[2];
                    r_buf[2] <= r_buf[3];
                end
                3'd2: begin
                    r_buf[0] <= r_buf[2];
                    r_buf[1] <= r_buf[3];
                end
                3'd3: begin
                    r_buf[0] <= r_buf[3];
                end
                default: begin
                end
            endcase
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_cp   <= r_held_cp;
            r_out_last <= i_cmd.push_last;
            r_out_end  <= i_cmd.push_last & r_at_end;
        end
    end

    // fill count, held flag and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= 3'd0;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_count <= r_count + 3'd1;
            end else if (i_cmd.advance) begin
                r_count <= n_count;
            end
            if (i_cmd.advance) begin
                r_held_valid <= 1'b1;
            end else if (i_cmd.push) begin
                r_held_valid <= 1'b0;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.outcome    = outcome;
    assign o_sts.held_valid = r_held_valid;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_code_point  = r_out_cp;
    assign o_last_of_run = r_out_last;
    assign o_stream_end  = r_out_end;

endmodule

`default_nettype wire

/* hdl/utf8d_ctrl.sv */
// controller of the utf-8 decoder: accepts bytes and sequences the buffer scan
// depends on utf8d_pkg
`default_nettype none

module utf8d_ctrl
    import utf8d_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   emits;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        emits      = (i_sts.outcome == OC_GOOD) || (i_sts.outcome == OC_BAD)
                  || (i_sts.outcome == OC_CLEAR);
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (emits) begin
                    // a further result follows, so the held one is not last
                    if (!i_sts.held_valid || i_sts.out_free) begin
                        o_cmd.advance = 1'b1;
                        o_cmd.push    = i_sts.held_valid;
                    end
                end else if (i_sts.held_valid) begin
                    // no further result: the held one closes the run
                    if (i_sts.out_free) begin
                        o_cmd.push      = 1'b1;
                        o_cmd.push_last = 1'b1;
                        n_state         = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/utf8_decoder_with_replacement_unit.sv */
// top level of the utf-8 to utf-32 decoder with replacement characters
// depends on utf8d_pkg, utf8d_ctrl and utf8d_datapath
`default_nettype none

// Decodes a UTF-8 byte stream into code points, one byte per input transfer,
// with tlast marking the final byte of the stream. Malformed input (bad lead,
// bad continuation, overlong form, surrogate or value above U+10FFFF) yields
// U+FFFD for the lead byte, and the buffered bytes after it are rescanned; a
// stream that ends inside a sequence yields a single U+FFFD. Each output
// transfer carries one code point; tlast marks the last result caused by an
// input byte and tuser the last result of the stream. The scan resolves one
// buffered sequence head per cycle while the output register can take the
// held result, and each result is held until the next scan step shows
// whether it is the last one of its byte. Output stalls hold the scan; a
// new byte is taken while a result still waits in the output register.
module utf8_decoder_with_replacement_unit
    import utf8d_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  wire logic [7:0]      i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic            i_s_axis_tlast,   // last_byte
    output logic                 o_m_axis_tvalid,
    input  wire logic            i_m_axis_tready,
    output logic [23:0]          o_m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic                 o_m_axis_tlast,   // last_of_run
    output logic                 o_m_axis_tuser    // [0] stream_end
);

    t_cmd            cmd;
    t_sts            sts;
    logic [CP_W-1:0] code_point;

    utf8d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    utf8d_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_byte        (i_s_axis_tdata),
        .i_last_byte   (i_s_axis_tlast),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_code_point  (code_point),
        .o_last_of_run (o_m_axis_tlast),
        .o_stream_end  (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {3'd0, code_point};

    // end of stream is only flagged on the last result of a byte
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (!o_m_axis_tuser || o_m_axis_tlast))
        else $error("stream end without last of run");

    // every emitted value is a unicode scalar
    a_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((code_point <= MAX_SCALAR)
            && ((code_point < SURROGATE_LO) || (code_point > SURROGATE_HI))))
        else $error("emitted value is not a scalar");

    // an accepted byte is scanned before the next transfer is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken during scan");

    // the buffer never sits full while waiting for input
    a_buffer_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (sts.outcome != OC_GOOD) && (sts.outcome != OC_BAD))
        else $error("resolvable sequence left in buffer");

endmodule

`default_nettype wire

/* sim/utf8_decoder_with_replacement_unit_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench of utf8_decoder_with_replacement_unit: random utf-8 byte streams
// in, code points predicted in the bench and compared field by field on every output transfer
// depends on utf8d_pkg and the decoder rtl

module utf8_decoder_with_replacement_unit_tb;
    import utf8d_pkg::*;

    localparam int RANDOM_BYTES = 400;
    localparam int TAIL_BYTES   = 50;    // no idling while the last bytes go out
    localparam int HOLD_AT      = 200;   // sender waits for a full drain at this byte
    localparam int DRAIN_CYCLES = 8;

    // one byte waiting to be sent
    typedef struct {
        logic [7:0] data;
        logic       fin;
        bit         hold;   // send only once every pending result has come
    } t_src_byte;

    // one decoded result as it should appear on the output
    typedef struct {
        logic [CP_W-1:0] code_point;
        logic            last_of_run;
        logic            stream_end;
    } t_code_unit;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [7:0]  i_s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic        i_s_axis_tlast  = 1'b0;    // last_byte
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;            // [20:0] code_point, [23:21] zero
    logic        o_m_axis_tlast;            // last_of_run
    logic        o_m_axis_tuser;            // [0] stream_end

    t_src_byte   utf8_bytes_q[$];
    t_code_unit  expected_code_points[$];

    // predictor state: open sequence
    logic [7:0]  seq_buf [4];
    int unsigned seq_cnt = 0;

    bit in_fire     = 1'b0;
    bit tail_phase  = 1'b0;
    bit failed      = 1'b0;
    bit hold_marked = 1'b0;
    int bytes_taken = 0;
    int bytes_total = 0;

    // idle burst state of the sender and the receiver
    int unsigned src_gap   = 0;
    bit          src_calm  = 1'b0;
    int unsigned sink_gap  = 0;
    bit          sink_calm = 1'b0;

    always #1 i_clk = ~i_clk;

    utf8_decoder_with_replacement_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // announced sequence length of a lead byte, 0 for a bad lead
    function automatic int unsigned lead_len(input logic [7:0] b, output logic [31:0] bits);
        bits = 32'd0;
        if (b[7] == 1'b0) begin
            bits = {24'd0, b};
            return 1;
        end
        if (b[7:5] == 3'b110) begin
            bits = {27'd0, b[4:0]};
            return 2;
        end
        if (b[7:4] == 4'b1110) begin
            bits = {28'd0, b[3:0]};
            return 3;
        end
        if (b[7:3] == 5'b11110) begin
            bits = {29'd0, b[2:0]};
            return 4;
        end
        return 0;
    endfunction

    // drop k bytes from the front of the open sequence
    task automatic shift_out(input int unsigned k);
        int unsigned i;
        if (k >= seq_cnt) begin
            seq_cnt = 0;
        end else begin
            for (i = 0; i + k < seq_cnt; i++)
                seq_buf[i] = seq_buf[i + k];
            seq_cnt -= k;
        end
    endtask

    // expected code points caused by one accepted byte
    task automatic decode_byte(input logic [7:0] b, input logic fin);
        logic [CP_W-1:0] cps [5];
        t_code_unit      unit;
        int              n;
        int              k;
        int unsigned     len;
        int unsigned     j;
        logic [31:0]     val;
        bit              ok;
        bit              stop;
        n    = 0;
        stop = 1'b0;
        if (seq_cnt < 4) begin
            seq_buf[seq_cnt] = b;
            seq_cnt++;
        end else begin
            seq_cnt = 0;
        end
        while (seq_cnt > 0 && !stop) begin
            len = lead_len(seq_buf[0], val);
            if (len == 0) begin
                // bad lead byte
                cps[n] = REPLACEMENT_CP;
                n++;
                shift_out(1);
            end else if (seq_cnt < len) begin
                // incomplete: wait, or one replacement at stream end
                if (fin) begin
                    cps[n] = REPLACEMENT_CP;
                    n++;
                    seq_cnt = 0;
                end
                stop = 1'b1;
            end else begin
                ok = 1'b1;
                for (j = 1; j < len; j++) begin
                    if (ok) begin
                        if (seq_buf[j][7:6] != 2'b10)
                            ok = 1'b0;
                        else
                            val = {val[25:0], seq_buf[j][5:0]};
                    end
                end
                // overlong, above range or surrogate
                if (ok) begin
                    if ((len == 2 && val < MIN_TWO_BYTE) ||
                        (len == 3 && val < MIN_THREE_BYTE) ||
                        (len == 4 && val < MIN_FOUR_BYTE) ||
                        val > MAX_SCALAR ||
                        (val >= SURROGATE_LO && val <= SURROGATE_HI))
                        ok = 1'b0;
                end
                if (!ok) begin
                    cps[n] = REPLACEMENT_CP;
                    n++;
                    shift_out(1);
                end else begin
                    cps[n] = val[CP_W-1:0];
                    n++;
                    shift_out(len);
                end
            end
        end
        for (k = 0; k < n; k++) begin
            unit.code_point  = cps[k];
            unit.last_of_run = (k == n - 1);
            unit.stream_end  = (k == n - 1) && fin;
            expected_code_points.insert(expected_code_points.size(), unit);
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic fin);
        t_src_byte s;
        s.data      = b;
        s.fin       = fin;
        s.hold      = hold_marked && !tail_phase && (utf8_bytes_q.size() == HOLD_AT);
        utf8_bytes_q.insert(utf8_bytes_q.size(), s);
    endtask

    // encode val in len bytes without any validity check, send the first keep of them,
    // optionally overwrite one byte with noise; fin goes on the last byte sent
    task automatic queue_seq(input logic [31:0] val, input int unsigned len,
                             input int unsigned keep, input int corrupt_at, input logic fin);
        logic [7:0]  enc [4];
        int unsigned i;
        case (len)
            1: enc[0] = {1'b0, val[6:0]};
            2: begin
                enc[0] = {3'b110, val[10:6]};
                enc[1] = {2'b10, val[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, val[15:12]};
                enc[1] = {2'b10, val[11:6]};
                enc[2] = {2'b10, val[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, val[20:18]};
                enc[1] = {2'b10, val[17:12]};
                enc[2] = {2'b10, val[11:6]};
                enc[3] = {2'b10, val[5:0]};
            end
        endcase
        if (corrupt_at >= 0)
            enc[corrupt_at] = 8'($urandom_range(0, 255));
        for (i = 0; i < keep; i++)
            queue_byte(enc[i], fin && (i == keep - 1));
    endtask

    // random valid scalar that needs exactly len bytes, range ends now and then
    function automatic logic [31:0] random_scalar(input int unsigned len);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] r;
        case (len)
            1:       begin lo = 32'h0;     hi = 32'h7F;     end
            2:       begin lo = 32'h80;    hi = 32'h7FF;    end
            3:       begin lo = 32'h800;   hi = 32'hFFFF;   end
            default: begin lo = 32'h10000; hi = 32'h10FFFF; end
        endcase
        case ($urandom_range(0, 15))
            0:       r = lo;
            1:       r = hi;
            default: r = $urandom_range(lo, hi);
        endcase
        if (r >= SURROGATE_LO && r <= SURROGATE_HI)
            r = r + 32'h800;
        return r;
    endfunction

    // reset
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // stimulus and end of run
    initial begin
        int unsigned len;
        int unsigned pick;
        int unsigned kind;
        logic [31:0] val;
        logic        fin;

        // directed: field extremes and every failure kind
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_seq(32'h80, 2, 2, -1, 1'b0);        // smallest two-byte value
        queue_seq(32'h7F, 2, 2, -1, 1'b0);        // overlong two-byte form
        queue_seq(32'h7FF, 3, 3, -1, 1'b0);       // overlong three-byte form
        queue_seq(32'hD800, 3, 3, -1, 1'b0);      // surrogate
        queue_seq(32'h10FFFF, 4, 4, -1, 1'b0);    // largest scalar
        queue_seq(32'h110000, 4, 4, -1, 1'b0);    // above the scalar range
        queue_byte(8'hF8, 1'b0);                  // bad lead
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hC3, 1'b0);                  // bad continuation
        queue_byte(8'h41, 1'b0);
        queue_seq(32'h1F600, 4, 3, -1, 1'b1);     // stream ends inside a sequence

        // random part: mostly well-formed text, some broken sequences and noise
        hold_marked = 1'b1;
        while (utf8_bytes_q.size() < RANDOM_BYTES + 27) begin
            fin  = ($urandom_range(0, 11) == 0);
            pick = $urandom_range(0, 99);
            len  = $urandom_range(1, 4);
            if (pick < 65) begin
                queue_seq(random_scalar(len), len, len, -1, fin);
            end else if (pick < 75) begin
                queue_seq(random_scalar(len), len, len, int'($urandom_range(0, len - 1)), fin);
            end else if (pick < 83) begin
                len = $urandom_range(2, 4);
                queue_seq(random_scalar(len), len, $urandom_range(1, len - 1), -1, fin);
            end else if (pick < 91) begin
                kind = $urandom_range(0, 2);
                if (kind == 0) begin
                    len = $urandom_range(2, 4);
                    case (len)
                        2:       val = $urandom_range(0, 32'h7F);
                        3:       val = $urandom_range(0, 32'h7FF);
                        default: val = $urandom_range(0, 32'hFFFF);
                    endcase
                    queue_seq(val, len, len, -1, fin);
                end else if (kind == 1) begin
                    queue_seq($urandom_range(32'hD800, 32'hDFFF), 3, 3, -1, fin);
                end else begin
                    queue_seq($urandom_range(32'h110000, 32'h1FFFFF), 4, 4, -1, fin);
                end
            end else begin
                queue_byte(8'($urandom_range(0, 255)), fin);
            end
        end
        queue_byte(8'h41, 1'b1);
        bytes_total = utf8_bytes_q.size();

        while (bytes_taken < bytes_total)
            @(negedge i_clk);
        while (expected_code_points.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (failed) begin
            $display("CHECK FAILED");
        end else begin
            $display("CHECK OK");
        end
        $finish;
    end

    // run limit
    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

    // byte driver
    always @(negedge i_clk) begin : src_drive
        t_src_byte nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!(i_s_axis_tvalid && !in_fire)) begin
            if (!tail_phase && $urandom_range(0, 63) == 0)
                src_calm = !src_calm;
            if (src_gap > 0) begin
                src_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (utf8_bytes_q.size() == 0) begin
                i_s_axis_tvalid <= 1'b0;
            end else if (utf8_bytes_q[0].hold && expected_code_points.size() != 0) begin
                // drain pause
                i_s_axis_tvalid <= 1'b0;
            end else if (!tail_phase && !src_calm && $urandom_range(0, 5) == 0) begin
                src_gap = $urandom_range(0, 4);
                i_s_axis_tvalid <= 1'b0;
            end else begin
                nxt = utf8_bytes_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= nxt.data;
                i_s_axis_tlast  <= nxt.fin;
            end
        end
    end

    // result receiver backpressure
    always @(negedge i_clk) begin : sink_drive
        if (!tail_phase && $urandom_range(0, 63) == 0)
            sink_calm = !sink_calm;
        if (sink_gap > 0) begin
            sink_gap--;
            i_m_axis_tready <= 1'b0;
        end else if (!tail_phase && !sink_calm && $urandom_range(0, 4) == 0) begin
            sink_gap = $urandom_range(0, 4);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // monitor: predict on each byte transfer, check each result transfer
    always @(posedge i_clk) begin : monitor
        t_code_unit want;
        tail_phase = (utf8_bytes_q.size() < TAIL_BYTES);
        in_fire = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (in_fire) begin
            decode_byte(i_s_axis_tdata, i_s_axis_tlast);
            bytes_taken++;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_code_points.size() == 0) begin
                $error("unexpected result transfer: code_point %h", o_m_axis_tdata[CP_W-1:0]);
                failed = 1'b1;
            end else begin
                want = expected_code_points.pop_front();
                if (o_m_axis_tdata[CP_W-1:0] !== want.code_point) begin
                    $error("code_point: expected %h, actual %h",
                           want.code_point, o_m_axis_tdata[CP_W-1:0]);
                    failed = 1'b1;
                end
                if (o_m_axis_tdata[23:CP_W] !== '0) begin
                    $error("tdata padding: expected 0, actual %h", o_m_axis_tdata[23:CP_W]);
                    failed = 1'b1;
                end
                if (o_m_axis_tlast !== want.last_of_run) begin
                    $error("last_of_run: expected %b, actual %b",
                           want.last_of_run, o_m_axis_tlast);
                    failed = 1'b1;
                end
                if (o_m_axis_tuser !== want.stream_end) begin
                    $error("stream_end: expected %b, actual %b",
                           want.stream_end, o_m_axis_tuser);
                    failed = 1'b1;
                end
            end
        end
    end

endmodule
